### sv/lcgx_pkg.sv
// Shared types and constants for the multi-round LCG keystream decipher.
// Used by lcgx_step_unit and multi_round_lcg_xor_decipher_unit.
`default_nettype none

package lcgx_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SEED       = 3'd0;
    localparam logic [2:0] REG_MULTIPLIER = 3'd1;
    localparam logic [2:0] REG_INCREMENT  = 3'd2;
    localparam logic [2:0] REG_MODULUS    = 3'd3;
    localparam logic [2:0] REG_ROUNDS     = 3'd4;
    localparam logic [2:0] REG_MSG_LEN    = 3'd5;

    // reset values of the round zero generator
    localparam logic [31:0] SEED_RST       = 32'd0;
    localparam logic [31:0] MULTIPLIER_RST = 32'd20011;
    localparam logic [31:0] INCREMENT_RST  = 32'd10007;
    localparam logic [31:0] MODULUS_RST    = 32'd100003;
    localparam logic [3:0]  ROUNDS_RST     = 4'd5;

    // round parameters are taken from up to the first four generator outputs
    localparam logic [2:0] CHAIN_LEN = 3'd4;

    // one round's generator state, one memory entry
    typedef struct packed {
        logic [31:0] val;
        logic [31:0] mul;
        logic [31:0] inc;
        logic [31:0] modu;
    } lcgx_entry_t;

    // request to the step unit
    typedef struct packed {
        logic        start;
        logic [31:0] x;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] m;
    } lcgx_req_t;

    // response from the step unit
    typedef struct packed {
        logic        done;
        logic [31:0] value;
        logic        zero_mod;
    } lcgx_resp_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_ABS,
        U_DIV,
        U_DONE
    } lcgx_ustate_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_DRV_WR,
        M_DRV_STEP,
        M_DRV_WAIT,
        M_RD,
        M_RD_WAIT,
        M_ST_WAIT,
        M_FIN
    } lcgx_mstate_t;

endpackage

`default_nettype wire

### sv/lcgx_step_unit.sv
// One generator step x = (x*a + b) rem m, truncated signed remainder.
// A multiply state and a sign state, then a restoring divider at one bit per cycle. Uses lcgx_pkg.
`default_nettype none

module lcgx_step_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  lcgx_pkg::lcgx_req_t  req,
    output lcgx_pkg::lcgx_resp_t resp
);

    lcgx_pkg::lcgx_ustate_t state_reg, state_next;

    logic [31:0] x_reg, a_reg, b_reg, m_reg;
    logic [31:0] prod_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [31:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic        zero_reg;

    logic [31:0] sum;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign sum     = prod_reg + b_reg;
    assign shifted = {rem_reg, dvd_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcgx_pkg::U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcgx_pkg::U_IDLE: begin
                if (req.start) begin
                    state_next = (req.m == 32'd0) ? lcgx_pkg::U_DONE : lcgx_pkg::U_MUL;
                end
            end
            lcgx_pkg::U_MUL:  state_next = lcgx_pkg::U_ABS;
            lcgx_pkg::U_ABS:  state_next = lcgx_pkg::U_DIV;
            lcgx_pkg::U_DIV: begin
                if (cnt_reg == 5'd31) begin
                    state_next = lcgx_pkg::U_DONE;
                end
            end
            lcgx_pkg::U_DONE: state_next = lcgx_pkg::U_IDLE;
            default:          state_next = lcgx_pkg::U_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lcgx_pkg::U_IDLE: begin
                x_reg    <= req.x;
                a_reg    <= req.a;
                b_reg    <= req.b;
                m_reg    <= req.m;
                zero_reg <= (req.m == 32'd0);
                rem_reg  <= 32'd0;
            end
            lcgx_pkg::U_MUL: begin
                prod_reg <= x_reg * a_reg;
            end
            lcgx_pkg::U_ABS: begin
                // magnitudes; remainder takes the dividend's sign
                dvd_reg <= sum[31] ? (32'd0 - sum) : sum;
                dvs_reg <= m_reg[31] ? (32'd0 - m_reg) : m_reg;
                neg_reg <= sum[31];
                cnt_reg <= 5'd0;
                rem_reg <= 32'd0;
            end
            lcgx_pkg::U_DIV: begin
                rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign resp.done     = (state_reg == lcgx_pkg::U_DONE);
    assign resp.zero_mod = zero_reg;
    assign resp.value    = zero_reg ? 32'd0 :
                           (neg_reg ? (32'd0 - rem_reg) : rem_reg);

endmodule

`default_nettype wire

### sv/multi_round_lcg_xor_decipher_unit.sv
// Top level of the multi-round LCG keystream XOR decipher.
// Depends on lcgx_pkg and lcgx_step_unit.
`default_nettype none

// One byte is taken at a time and its plaintext appears on the m_ side as
// one beat. Each active round costs one generator step in the shared step
// unit (a multiply state, a sign state, the divider states and a result
// state) plus a round-memory read and write. The first byte of a message
// also derives the round parameters from min(message_length,4) generator
// steps per round. The per-round generator state sits in a small
// synchronous memory that is read and written back once per round.
// modulus_fault (tuser) is sticky until reset. A new byte may enter while
// the previous result still waits.
module multi_round_lcg_xor_decipher_unit #(
    parameter int MAX_ROUNDS = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    // configuration write channel
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [2:0] cfg_index,
    input  wire [31:0] cfg_data,
    // input stream
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] cipher_byte
    // output stream
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] plain_byte
    output logic       m_tuser    // [0] modulus_fault
);

    localparam int AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam int CW = $clog2(MAX_ROUNDS + 1);

    // configuration registers
    logic [31:0] seed_reg, mult_reg, incr_reg, mod_reg;
    logic [3:0]  rounds_reg;
    logic [23:0] msg_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= lcgx_pkg::SEED_RST;
            mult_reg    <= lcgx_pkg::MULTIPLIER_RST;
            incr_reg    <= lcgx_pkg::INCREMENT_RST;
            mod_reg     <= lcgx_pkg::MODULUS_RST;
            rounds_reg  <= lcgx_pkg::ROUNDS_RST;
            msg_len_reg <= 24'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lcgx_pkg::REG_SEED:       seed_reg    <= cfg_data;
                lcgx_pkg::REG_MULTIPLIER: mult_reg    <= cfg_data;
                lcgx_pkg::REG_INCREMENT:  incr_reg    <= cfg_data;
                lcgx_pkg::REG_MODULUS:    mod_reg     <= cfg_data;
                lcgx_pkg::REG_ROUNDS:     rounds_reg  <= cfg_data[3:0];
                lcgx_pkg::REG_MSG_LEN:    msg_len_reg <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // active rounds and chain length
    logic [CW-1:0] n_rounds;
    logic [2:0]    chain_k;

    assign n_rounds = (int'(rounds_reg) > MAX_ROUNDS) ? CW'(MAX_ROUNDS) : CW'(rounds_reg);
    assign chain_k  = (msg_len_reg < 24'(lcgx_pkg::CHAIN_LEN)) ? msg_len_reg[2:0]
                                                                : lcgx_pkg::CHAIN_LEN;

    // round state memory, entries read as zero until first written
    lcgx_pkg::lcgx_entry_t mem [MAX_ROUNDS];
    lcgx_pkg::lcgx_entry_t rd_data_reg;
    lcgx_pkg::lcgx_entry_t mem_wdata;
    lcgx_pkg::lcgx_entry_t entry;
    logic [MAX_ROUNDS-1:0] vld_reg;
    logic                  rd_vld_reg;
    logic                  mem_we, mem_re;

    // sequencer state
    lcgx_pkg::lcgx_mstate_t state_reg, state_next;
    logic [CW-1:0] r_reg;
    logic [2:0]    j_reg;
    logic [31:0]   p_reg [4];
    logic [31:0]   cx_reg, ca_reg, cb_reg, cm_reg;
    logic [7:0]    byte_reg;
    logic [23:0]   pos_reg;
    logic [23:0]   pos_inc;
    logic          setup_reg;
    logic          fault_reg;
    logic          out_free;

    lcgx_pkg::lcgx_req_t  ureq;
    lcgx_pkg::lcgx_resp_t uresp;

    assign entry    = rd_vld_reg ? rd_data_reg : '0;
    assign pos_inc  = pos_reg + 24'd1;
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (state_reg == lcgx_pkg::M_IDLE);

    assign mem_we = ((state_reg == lcgx_pkg::M_DRV_WR) && (r_reg < n_rounds)) ||
                    ((state_reg == lcgx_pkg::M_ST_WAIT) && uresp.done);
    assign mem_re = (state_reg == lcgx_pkg::M_RD) && (r_reg < n_rounds);

    always_comb begin
        if (state_reg == lcgx_pkg::M_DRV_WR) begin
            mem_wdata = '{val: p_reg[0], mul: p_reg[1], inc: p_reg[2], modu: p_reg[3]};
        end else begin
            mem_wdata = '{val: uresp.value, mul: entry.mul, inc: entry.inc,
                          modu: entry.modu};
        end
    end

    // memory port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[r_reg[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[r_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[r_reg[AW-1:0]] <= 1'b1;
            end
            if (mem_re) begin
                rd_vld_reg <= vld_reg[r_reg[AW-1:0]];
            end
        end
    end

    // step unit requests
    always_comb begin
        ureq = '0;
        if ((state_reg == lcgx_pkg::M_DRV_STEP) && (j_reg < chain_k)) begin
            ureq = '{start: 1'b1, x: cx_reg, a: ca_reg, b: cb_reg, m: cm_reg};
        end else if (state_reg == lcgx_pkg::M_RD_WAIT) begin
            ureq = '{start: 1'b1, x: entry.val, a: entry.mul, b: entry.inc,
                     m: entry.modu};
        end
    end

    lcgx_step_unit u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .resp    (uresp)
    );

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcgx_pkg::M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcgx_pkg::M_IDLE: begin
                if (s_tvalid) begin
                    state_next = setup_reg ? lcgx_pkg::M_RD : lcgx_pkg::M_DRV_WR;
                end
            end
            lcgx_pkg::M_DRV_WR: begin
                state_next = (r_reg < n_rounds) ? lcgx_pkg::M_DRV_STEP : lcgx_pkg::M_RD;
            end
            lcgx_pkg::M_DRV_STEP: begin
                state_next = (j_reg < chain_k) ? lcgx_pkg::M_DRV_WAIT : lcgx_pkg::M_DRV_WR;
            end
            lcgx_pkg::M_DRV_WAIT: begin
                if (uresp.done) begin
                    state_next = lcgx_pkg::M_DRV_STEP;
                end
            end
            lcgx_pkg::M_RD: begin
                state_next = (r_reg < n_rounds) ? lcgx_pkg::M_RD_WAIT : lcgx_pkg::M_FIN;
            end
            lcgx_pkg::M_RD_WAIT: state_next = lcgx_pkg::M_ST_WAIT;
            lcgx_pkg::M_ST_WAIT: begin
                if (uresp.done) begin
                    state_next = lcgx_pkg::M_RD;
                end
            end
            lcgx_pkg::M_FIN: begin
                if (out_free) begin
                    state_next = lcgx_pkg::M_IDLE;
                end
            end
            default: state_next = lcgx_pkg::M_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg <= 1'b0;
            fault_reg <= 1'b0;
            pos_reg   <= 24'd0;
            m_tvalid  <= 1'b0;
        end else begin
            if ((state_reg == lcgx_pkg::M_IDLE) && s_tvalid) begin
                setup_reg <= 1'b1;
            end
            if (uresp.done && uresp.zero_mod) begin
                fault_reg <= 1'b1;
            end
            if ((state_reg == lcgx_pkg::M_FIN) && out_free) begin
                m_tvalid <= 1'b1;
                if ((msg_len_reg != 24'd0) && (pos_inc == msg_len_reg)) begin
                    pos_reg   <= 24'd0;
                    setup_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_inc;
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            lcgx_pkg::M_IDLE: begin
                byte_reg <= s_tdata;
                r_reg    <= '0;
                p_reg[0] <= seed_reg;
                p_reg[1] <= mult_reg;
                p_reg[2] <= incr_reg;
                p_reg[3] <= mod_reg;
            end
            lcgx_pkg::M_DRV_WR: begin
                if (r_reg < n_rounds) begin
                    cx_reg <= p_reg[0];
                    ca_reg <= p_reg[1];
                    cb_reg <= p_reg[2];
                    cm_reg <= p_reg[3];
                    j_reg  <= 3'd0;
                end else begin
                    r_reg <= '0;
                end
            end
            lcgx_pkg::M_DRV_STEP: begin
                if (j_reg >= chain_k) begin
                    r_reg <= r_reg + CW'(1);
                end
            end
            lcgx_pkg::M_DRV_WAIT: begin
                if (uresp.done) begin
                    cx_reg             <= uresp.value;
                    p_reg[j_reg[1:0]]  <= uresp.value;
                    j_reg              <= j_reg + 3'd1;
                end
            end
            lcgx_pkg::M_ST_WAIT: begin
                if (uresp.done) begin
                    byte_reg <= byte_reg ^ uresp.value[7:0];
                    r_reg    <= r_reg + CW'(1);
                end
            end
            lcgx_pkg::M_FIN: begin
                if (out_free) begin
                    m_tdata <= byte_reg;
                    m_tuser <= fault_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/lcgx_checker.sv
// Port-level checks for multi_round_lcg_xor_decipher_unit, bound to the top.
// Sees only the top level's ports.
`default_nettype none

module lcgx_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       cfg_valid,
    input wire       cfg_ready,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tuser
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // one byte in flight: input closes after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a byte is in work");

    // fault flag is sticky
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |=> !m_tvalid || m_tuser)
        else $error("modulus fault flag cleared");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind multi_round_lcg_xor_decipher_unit lcgx_checker u_lcgx_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for multi_round_lcg_xor_decipher_unit.
// Drives stream bytes and register writes, predicts each plaintext beat
// internally; needs lcgx_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ROUNDS = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;

    typedef struct {
        logic [7:0] plain;
        logic       fault;
    } plain_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    multi_round_lcg_xor_decipher_unit #(.MAX_ROUNDS(MAX_ROUNDS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // shadow registers and generator state
    logic [31:0] sh_seed, sh_mul, sh_inc, sh_mod;
    logic [3:0]  sh_rounds;
    logic [23:0] sh_msg_len;
    logic [31:0] gen_val[MAX_ROUNDS], gen_mul[MAX_ROUNDS];
    logic [31:0] gen_inc[MAX_ROUNDS], gen_mod[MAX_ROUNDS];
    logic [23:0] msg_pos;
    logic        chain_ready;
    logic        fault_flag;

    logic [7:0]  cipher_q[$];
    plain_beat_t plain_q[$];
    int          errors = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          s_acc = 1'b0;
    int          idle_cycles = 0;

    // one generator step: wrapping x*a+b, truncated signed remainder
    function automatic logic [31:0] lcg_next(logic [31:0] x, logic [31:0] a,
                                             logic [31:0] b, logic [31:0] m);
        logic [31:0] v;
        longint      num, den;
        v = x * a + b;
        if (m == 32'd0) begin
            fault_flag = 1'b1;
            return 32'd0;
        end
        num = longint'($signed(v));
        den = longint'($signed(m));
        return 32'(num % den);
    endfunction

    function automatic int live_rounds();
        return (sh_rounds > MAX_ROUNDS) ? MAX_ROUNDS : int'(sh_rounds);
    endfunction

    // chain round parameters from each round's first outputs
    function automatic void build_chain();
        logic [31:0] p[4];
        logic [31:0] x;
        int k;
        p[0] = sh_seed; p[1] = sh_mul; p[2] = sh_inc; p[3] = sh_mod;
        k = (sh_msg_len < 4) ? int'(sh_msg_len) : 4;
        for (int r = 0; r < live_rounds(); r++) begin
            gen_val[r] = p[0]; gen_mul[r] = p[1];
            gen_inc[r] = p[2]; gen_mod[r] = p[3];
            x = p[0];
            for (int j = 0; j < k; j++) begin
                x = lcg_next(x, gen_mul[r], gen_inc[r], gen_mod[r]);
                p[j] = x;
            end
        end
    endfunction

    function automatic plain_beat_t decipher(logic [7:0] c);
        plain_beat_t pb;
        logic [7:0] b;
        b = c;
        if (!chain_ready) begin
            build_chain();
            chain_ready = 1'b1;
        end
        for (int r = 0; r < live_rounds(); r++) begin
            gen_val[r] = lcg_next(gen_val[r], gen_mul[r], gen_inc[r], gen_mod[r]);
            b ^= gen_val[r][7:0];
        end
        msg_pos = msg_pos + 24'd1;
        if (sh_msg_len != 0 && msg_pos == sh_msg_len) begin
            msg_pos = '0;
            chain_ready = 1'b0;
        end
        pb.plain = b;
        pb.fault = fault_flag;
        return pb;
    endfunction

    function automatic void shadow_write(logic [2:0] idx, logic [31:0] d);
        case (idx)
            lcgx_pkg::REG_SEED:       sh_seed = d;
            lcgx_pkg::REG_MULTIPLIER: sh_mul = d;
            lcgx_pkg::REG_INCREMENT:  sh_inc = d;
            lcgx_pkg::REG_MODULUS:    sh_mod = d;
            lcgx_pkg::REG_ROUNDS:     sh_rounds = d[3:0];
            lcgx_pkg::REG_MSG_LEN:    sh_msg_len = d[23:0];
            default: ;
        endcase
    endfunction

    // input beats: predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            s_acc = 1'b1;
            plain_q.push_back(decipher(cipher_q.pop_front()));
        end
    end

    // driver: hold an offered byte until taken, else present the next or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_acc) begin
            s_tvalid <= 1'b1;
        end else if (cipher_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
            s_tvalid <= 1'b1;
            s_tdata  <= cipher_q[0];
        end else begin
            s_tvalid <= 1'b0;
        end
        s_acc = 1'b0;
    end

    // monitor: output backpressure, with one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(99) >= 28;
        end
    end

    // result check
    always @(posedge aclk) begin
        plain_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_q.size() == 0) begin
                $display("%0t: unexpected beat plain=%02h fault=%0b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = plain_q.pop_front();
                if (m_tdata !== want.plain) begin
                    $display("%0t: plain_byte expected %02h actual %02h",
                             $time, want.plain, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.fault) begin
                    $display("%0t: modulus_fault expected %0b actual %0b",
                             $time, want.fault, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn && (cipher_q.size() > 0 || plain_q.size() > 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_write(idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cipher_q.size() > 0 || plain_q.size() > 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(int'($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++) cipher_q.push_back(8'($urandom));
    endtask

    initial begin
        int n_msg;
        logic [31:0] mval;
        sh_seed = lcgx_pkg::SEED_RST; sh_mul = lcgx_pkg::MULTIPLIER_RST;
        sh_inc = lcgx_pkg::INCREMENT_RST; sh_mod = lcgx_pkg::MODULUS_RST;
        sh_rounds = lcgx_pkg::ROUNDS_RST; sh_msg_len = '0;
        for (int r = 0; r < MAX_ROUNDS; r++) begin
            gen_val[r] = '0; gen_mul[r] = '0; gen_inc[r] = '0; gen_mod[r] = '0;
        end
        msg_pos = '0; chain_ready = 1'b0; fault_flag = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: reset settings, byte extremes
        cipher_q.push_back(8'h00); cipher_q.push_back(8'hff);
        cipher_q.push_back(8'h55); cipher_q.push_back(8'haa);
        drain();
        // short message, chain only partly replaced
        reg_write(lcgx_pkg::REG_MSG_LEN, 32'd3);
        send_bytes(4);
        drain();
        // pass-through and saturated rounds
        reg_write(lcgx_pkg::REG_ROUNDS, 32'd0);
        send_bytes(2);
        drain();
        reg_write(lcgx_pkg::REG_ROUNDS, 32'd15);
        reg_write(lcgx_pkg::REG_MSG_LEN, 32'd5);
        send_bytes(5);
        drain();
        // remainder overflow: -2^31 rem -1
        reg_write(lcgx_pkg::REG_SEED, 32'd0);
        reg_write(lcgx_pkg::REG_MULTIPLIER, 32'd0);
        reg_write(lcgx_pkg::REG_INCREMENT, 32'h8000_0000);
        reg_write(lcgx_pkg::REG_MODULUS, 32'hffff_ffff);
        reg_write(lcgx_pkg::REG_ROUNDS, 32'd1);
        reg_write(lcgx_pkg::REG_MSG_LEN, 32'd2);
        send_bytes(2);
        drain();
        // index outside the register map is ignored
        reg_write(3'd6, 32'hdead_beef);
        reg_write(3'd7, 32'h1234_5678);
        reg_write(lcgx_pkg::REG_MSG_LEN, 32'hff_ffff);
        reg_write(lcgx_pkg::REG_ROUNDS, 32'd8);
        send_bytes(3);
        drain();

        // random phases, each a fresh setting
        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph == 3);
            reg_write(lcgx_pkg::REG_SEED, pick_word());
            reg_write(lcgx_pkg::REG_MULTIPLIER, pick_word());
            reg_write(lcgx_pkg::REG_INCREMENT, pick_word());
            mval = pick_word();
            if (ph == 9) mval = 32'd0;   // zero modulus makes the fault sticky
            reg_write(lcgx_pkg::REG_MODULUS, mval);
            reg_write(lcgx_pkg::REG_ROUNDS,
                      (ph % 5 == 4) ? $urandom_range(15) : $urandom_range(8));
            case ($urandom_range(5))
                0: reg_write(lcgx_pkg::REG_MSG_LEN, 32'd0);
                1: reg_write(lcgx_pkg::REG_MSG_LEN, 32'(1 + $urandom_range(3)));
                2: reg_write(lcgx_pkg::REG_MSG_LEN, 32'h00ff_ffff);
                default: reg_write(lcgx_pkg::REG_MSG_LEN, 32'(4 + $urandom_range(16)));
            endcase
            n_msg = 70 + $urandom_range(30);
            if (ph == 6) begin
                // receiver holds off while bytes keep coming
                hold_go = 1'b1;
            end
            send_bytes(n_msg);
            drain();
        end
        calm = 1'b0;

        repeat (400) @(posedge aclk);
        if (errors == 0 && plain_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### files.f
sv/lcgx_pkg.sv
sv/lcgx_step_unit.sv
sv/multi_round_lcg_xor_decipher_unit.sv
sv/lcgx_checker.sv
dv/tb.sv
